/* hdl/tsfm_pkg.sv */
// ----------------------------------------------------------------------------
// tsfm_pkg
// Shared widths, field offsets, register indexes, FSM states and helper
// functions for the touch sample filter / calibration map / tap block.
// ----------------------------------------------------------------------------
package tsfm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COORD_W     = 12;
    localparam int CAL_W       = 16;
    localparam int TIME_W      = 32;
    localparam int DB_W        = 16;

    // (raw - low) always fits 18 bits signed for SAMPLE_BITS up to 16
    localparam int DIFF_W      = 18;
    localparam int SPAN_W      = CAL_W + 1;
    localparam int PROD_W      = DIFF_W + COORD_W + 1;
    localparam int NUM_W       = 30;
    localparam int DIV_STEPS   = NUM_W / 2;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

    localparam int RAIL_W      = 17;
    localparam logic [RAIL_W-1:0] RAIL_LOW  = RAIL_W'(100);
    localparam logic [RAIL_W-1:0] RAIL_HIGH = RAIL_W'(4000);

    // input beat layout
    localparam int IN_PEN_LSB  = 0;
    localparam int IN_X0_LSB   = 1;
    localparam int IN_X1_LSB   = IN_X0_LSB + SAMPLE_BITS;
    localparam int IN_X2_LSB   = IN_X1_LSB + SAMPLE_BITS;
    localparam int IN_Y0_LSB   = IN_X2_LSB + SAMPLE_BITS;
    localparam int IN_Y1_LSB   = IN_Y0_LSB + SAMPLE_BITS;
    localparam int IN_Y2_LSB   = IN_Y1_LSB + SAMPLE_BITS;
    localparam int IN_NOW_LSB  = IN_Y2_LSB + SAMPLE_BITS;
    localparam int IN_BITS     = IN_NOW_LSB + TIME_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // result beat layout
    localparam int OUT_VALID_BIT = 0;
    localparam int OUT_SX_LSB    = 1;
    localparam int OUT_SY_LSB    = OUT_SX_LSB + COORD_W;
    localparam int OUT_TAP_BIT   = OUT_SY_LSB + COORD_W;
    localparam int OUT_BITS      = OUT_TAP_BIT + 1;
    localparam int M_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_W  = 8;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SWAP_AXES    = 8'd0,
        CFG_RAW_X_LOW    = 8'd1,
        CFG_RAW_X_HIGH   = 8'd2,
        CFG_RAW_Y_LOW    = 8'd3,
        CFG_RAW_Y_HIGH   = 8'd4,
        CFG_SCREEN_X_MAX = 8'd5,
        CFG_SCREEN_Y_MAX = 8'd6,
        CFG_DEBOUNCE_MS  = 8'd7
    } cfg_idx_e;

    localparam logic [CAL_W-1:0]   RST_RAW_LOW  = CAL_W'(200);
    localparam logic [CAL_W-1:0]   RST_RAW_HIGH = CAL_W'(3900);
    localparam logic [COORD_W-1:0] RST_X_MAX    = COORD_W'(319);
    localparam logic [COORD_W-1:0] RST_Y_MAX    = COORD_W'(239);
    localparam logic [DB_W-1:0]    RST_DEBOUNCE = DB_W'(50);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MED,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [NUM_W-1:0]  num;
        logic signed [SPAN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             neg;
        logic [NUM_W-1:0] mag;
    } div_rsp_t;

    function automatic logic [SAMPLE_BITS-1:0] med3(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c
    );
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] mid;
        lo  = (a > b) ? b : a;
        hi  = (a > b) ? a : b;
        mid = (hi > c) ? c : hi;
        return (lo > mid) ? lo : mid;
    endfunction

    function automatic logic in_rail(input logic [SAMPLE_BITS-1:0] v);
        logic [RAIL_W-1:0] w;
        w = RAIL_W'(v);
        return (w >= RAIL_LOW) && (w <= RAIL_HIGH);
    endfunction

endpackage

/* hdl/tsfm_div.sv */
// ----------------------------------------------------------------------------
// tsfm_div
// Shared signed divider, truncating toward zero. Works on magnitudes,
// restoring algorithm, two quotient bits per cycle. Result is a magnitude
// plus a negative flag, presented with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module tsfm_div
    import tsfm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic                  neg_reg,   neg_next;
    logic [STEP_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0]      qr_reg,    qr_next;
    logic [SPAN_W-1:0]     rem_reg,   rem_next;
    logic [SPAN_W-1:0]     den_reg,   den_next;

    logic [SPAN_W:0]   sh1, sh2;
    logic [SPAN_W:0]   r1,  r2;
    logic              ge1, ge2;
    logic [NUM_W-1:0]  num_mag;
    logic [SPAN_W-1:0] den_mag;

    assign num_mag = req.num[NUM_W-1]  ? NUM_W'(-req.num)  : NUM_W'(req.num);
    assign den_mag = req.den[SPAN_W-1] ? SPAN_W'(-req.den) : SPAN_W'(req.den);

    always_comb begin
        sh1 = {rem_reg, qr_reg[NUM_W-1]};
        ge1 = sh1 >= {1'b0, den_reg};
        r1  = ge1 ? sh1 - {1'b0, den_reg} : sh1;
        sh2 = {r1[SPAN_W-1:0], qr_reg[NUM_W-2]};
        ge2 = sh2 >= {1'b0, den_reg};
        r2  = ge2 ? sh2 - {1'b0, den_reg} : sh2;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        qr_next   = qr_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            neg_next  = req.num[NUM_W-1] ^ req.den[SPAN_W-1];
            cnt_next  = STEP_CNT_W'(DIV_STEPS - 1);
            qr_next   = num_mag;
            rem_next  = '0;
            den_next  = den_mag;
        end else if (busy_reg) begin
            qr_next  = {qr_reg[NUM_W-3:0], ge1, ge2};
            rem_next = r2[SPAN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        qr_reg  <= qr_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.neg  = neg_reg;
    assign rsp.mag  = qr_reg;

endmodule

/* hdl/touch_sample_filter_map_tap.sv */
// ----------------------------------------------------------------------------
// touch_sample_filter_map_tap
// Median-of-three filter, rail rejection, calibration map and tap debounce
// for a resistive touch panel.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one beat per touch report: pen line, three raw X and
//   three raw Y conversions, millisecond time. m_* gives one beat per report:
//   touch_valid, screen_x, screen_y, tap. cfg_* writes calibration registers
//   (index in cfg_addr, value in cfg_data); cfg_ready is always high and
//   writes belong in idle periods only.
//   Flow: s_tready is high only in the idle state, so one report is in
//   flight at a time. A report that is not a valid touch goes from the
//   median state straight to the output state. A valid touch runs two
//   signed divisions, one per axis, on the shared divider (two quotient
//   bits per cycle) with a multiply before each; an axis with a zero span
//   skips its division. A new report is accepted only after the previous
//   one has been loaded into the output register.
//   A result waiting in the output register does not block the next
//   acceptance; a finished result is held back only while the previous one
//   still stalls on m_tready.
//   Reset (aresetn low, synchronous) restores default calibration, clears
//   the pressed flag and the last edge time, and empties the output register.
// ----------------------------------------------------------------------------
module touch_sample_filter_map_tap
    import tsfm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // pen_down, x_sample_0, x_sample_1, x_sample_2, y_sample_0, y_sample_1,
    // y_sample_2, now_ms (from bit 0 up), zero padded
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // touch_valid, screen_x, screen_y, tap (from bit 0 up), zero padded
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // calibration registers
    logic               swap_reg;
    logic [CAL_W-1:0]   xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic [COORD_W-1:0] xmax_reg, ymax_reg;
    logic [DB_W-1:0]    db_reg;

    state_t state_reg, state_next;

    logic [IN_BITS-1:0]     in_reg;
    logic [SAMPLE_BITS-1:0] ax_reg, ay_reg;
    logic                   valid_reg;
    logic                   tap_reg;
    logic                   axis_reg;
    logic [COORD_W-1:0]     sx_reg, sy_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic signed [SPAN_W-1:0] span_reg;
    logic                   pressed_reg;
    logic [TIME_W-1:0]      last_edge_reg;
    logic [M_TDATA_W-1:0]   out_reg;
    logic                   out_valid_reg;

    // control strobes
    logic ld_in, ld_med, ld_mul, axis_done, ld_out;

    // median / debounce terms
    logic [SAMPLE_BITS-1:0] mx, my;
    logic                   med_valid;
    logic [TIME_W-1:0]      now_ms, elapsed;
    logic                   past_db;

    // mapping terms
    logic [SAMPLE_BITS-1:0]   raw_sel;
    logic [CAL_W-1:0]         lo_sel, hi_sel;
    logic [COORD_W-1:0]       top_sel;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [SPAN_W-1:0] span;
    logic [COORD_W-1:0]       clamped;
    logic [COORD_W-1:0]       axis_val;
    logic                     span_zero;

    div_req_t div_req;
    div_rsp_t div_rsp;

    tsfm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_reg <= 1'b0;
            xlo_reg  <= RST_RAW_LOW;
            xhi_reg  <= RST_RAW_HIGH;
            ylo_reg  <= RST_RAW_LOW;
            yhi_reg  <= RST_RAW_HIGH;
            xmax_reg <= RST_X_MAX;
            ymax_reg <= RST_Y_MAX;
            db_reg   <= RST_DEBOUNCE;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_SWAP_AXES:    swap_reg <= cfg_data[0];
                CFG_RAW_X_LOW:    xlo_reg  <= cfg_data[CAL_W-1:0];
                CFG_RAW_X_HIGH:   xhi_reg  <= cfg_data[CAL_W-1:0];
                CFG_RAW_Y_LOW:    ylo_reg  <= cfg_data[CAL_W-1:0];
                CFG_RAW_Y_HIGH:   yhi_reg  <= cfg_data[CAL_W-1:0];
                CFG_SCREEN_X_MAX: xmax_reg <= cfg_data[COORD_W-1:0];
                CFG_SCREEN_Y_MAX: ymax_reg <= cfg_data[COORD_W-1:0];
                CFG_DEBOUNCE_MS:  db_reg   <= cfg_data[DB_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- median, rail check, debounce ----
    assign mx = med3(in_reg[IN_X0_LSB +: SAMPLE_BITS], in_reg[IN_X1_LSB +: SAMPLE_BITS],
                     in_reg[IN_X2_LSB +: SAMPLE_BITS]);
    assign my = med3(in_reg[IN_Y0_LSB +: SAMPLE_BITS], in_reg[IN_Y1_LSB +: SAMPLE_BITS],
                     in_reg[IN_Y2_LSB +: SAMPLE_BITS]);
    assign med_valid = in_reg[IN_PEN_LSB] && in_rail(mx) && in_rail(my);
    assign now_ms    = in_reg[IN_NOW_LSB +: TIME_W];
    assign elapsed   = now_ms - last_edge_reg;
    assign past_db   = elapsed > TIME_W'(db_reg);

    // ---- per-axis map operands ----
    assign raw_sel = axis_reg ? ay_reg   : ax_reg;
    assign lo_sel  = axis_reg ? ylo_reg  : xlo_reg;
    assign hi_sel  = axis_reg ? yhi_reg  : xhi_reg;
    assign top_sel = axis_reg ? ymax_reg : xmax_reg;

    assign diff = $signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, raw_sel})
                - $signed({{(DIFF_W-CAL_W){lo_sel[CAL_W-1]}}, lo_sel});
    assign prod = diff * $signed({1'b0, top_sel});
    assign span = $signed({hi_sel[CAL_W-1], hi_sel}) - $signed({lo_sel[CAL_W-1], lo_sel});
    assign span_zero = (span_reg == '0);

    // negative quotient clamps to zero, large one to the screen edge
    always_comb begin
        if (div_rsp.neg && (div_rsp.mag != '0)) begin
            clamped = '0;
        end else if (div_rsp.mag > NUM_W'(top_sel)) begin
            clamped = top_sel;
        end else begin
            clamped = div_rsp.mag[COORD_W-1:0];
        end
    end
    assign axis_val = (state_reg == ST_DIV) ? '0 : clamped;

    assign div_req.num = num_reg;
    assign div_req.den = span_reg;

    // ---- FSM: next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MED;
            ST_MED:  state_next = med_valid ? ST_MUL : ST_OUT;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV: begin
                if (!span_zero) begin
                    state_next = ST_WAIT;
                end else begin
                    state_next = axis_reg ? ST_OUT : ST_MUL;
                end
            end
            ST_WAIT: if (div_rsp.done) state_next = axis_reg ? ST_OUT : ST_MUL;
            ST_OUT:  if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---- FSM: outputs ----
    always_comb begin
        s_tready      = 1'b0;
        ld_in         = 1'b0;
        ld_med        = 1'b0;
        ld_mul        = 1'b0;
        axis_done     = 1'b0;
        ld_out        = 1'b0;
        div_req.start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ld_in    = s_tvalid;
            end
            ST_MED:  ld_med = 1'b1;
            ST_MUL:  ld_mul = 1'b1;
            ST_DIV: begin
                div_req.start = !span_zero;
                axis_done     = span_zero;
            end
            ST_WAIT: axis_done = div_rsp.done;
            ST_OUT:  ld_out = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pressed_reg   <= 1'b0;
            last_edge_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ld_med && past_db && (med_valid != pressed_reg)) begin
                pressed_reg   <= med_valid;
                last_edge_reg <= now_ms;
            end
            if (ld_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_in) begin
            in_reg <= s_tdata[IN_BITS-1:0];
        end
        if (ld_med) begin
            ax_reg    <= swap_reg ? my : mx;
            ay_reg    <= swap_reg ? mx : my;
            valid_reg <= med_valid;
            tap_reg   <= med_valid && !pressed_reg && past_db;
            axis_reg  <= 1'b0;
            sx_reg    <= '0;
            sy_reg    <= '0;
        end
        if (ld_mul) begin
            num_reg  <= prod[NUM_W-1:0];
            span_reg <= span;
        end
        if (axis_done) begin
            if (axis_reg) begin
                sy_reg <= axis_val;
            end else begin
                sx_reg <= axis_val;
            end
            axis_reg <= 1'b1;
        end
        if (ld_out) begin
            out_reg <= M_TDATA_W'({tap_reg, sy_reg, sx_reg, valid_reg});
        end
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_valid_reg;

endmodule

/* hdl/tsfm_checker.sv */
// ----------------------------------------------------------------------------
// tsfm_checker
// Port-level checks for touch_sample_filter_map_tap, bound to the top level.
// ----------------------------------------------------------------------------
module tsfm_checker
    import tsfm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    // output register empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one report in flight: no accept in the cycle right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // a tap only comes with a valid touch
    a_tap_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_TAP_BIT] |-> m_tdata[OUT_VALID_BIT])
        else $error("tap without valid touch");

    // a rejected touch carries zero coordinates
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OUT_VALID_BIT] |-> m_tdata[OUT_TAP_BIT-1:OUT_SX_LSB] == '0)
        else $error("rejected touch with nonzero coordinates");

endmodule

bind touch_sample_filter_map_tap tsfm_checker u_tsfm_checker (.*);

/* bench/touch_report_checker.sv */
// ----------------------------------------------------------------------------
// touch_report_checker
// Watches the report, result and register channels of the touch filter,
// keeps its own copy of the calibration and debounce state, works out each
// result from the accepted report and compares it with the beat that leaves.
// ----------------------------------------------------------------------------
module touch_report_checker
    import tsfm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           error_count,
    output int unsigned           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               touch;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               tap;
    } touch_result_t;

    // calibration copy
    logic                    swap_xy;
    logic signed [CAL_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic [COORD_W-1:0]      x_top, y_top;
    logic [DB_W-1:0]         hold_ms;
    // debounce state
    logic                    pen_held;
    logic [TIME_W-1:0]       edge_ms;

    touch_result_t reports_in_flight[$];
    int unsigned   failures = 0;
    int unsigned   in_flight = 0;

    assign error_count   = failures;
    assign pending_count = in_flight;

    function automatic logic [SAMPLE_BITS-1:0] middle_of(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c
    );
        logic [SAMPLE_BITS-1:0] lo, hi;
        lo = (a > b) ? b : a;
        hi = (a > b) ? a : b;
        if (c >= hi) return hi;
        if (c <= lo) return lo;
        return c;
    endfunction

    // (raw - lo) * top / (hi - lo), truncated toward zero, clamped to 0..top
    function automatic logic [COORD_W-1:0] scale_axis(
        input logic [SAMPLE_BITS-1:0] raw,
        input logic signed [CAL_W-1:0] lo,
        input logic signed [CAL_W-1:0] hi,
        input logic [COORD_W-1:0]      top
    );
        longint span, prod, q;
        span = longint'(hi) - longint'(lo);
        if (span == 0) return '0;
        prod = (longint'(raw) - longint'(lo)) * longint'(top);
        q = prod / span;
        if (q < 0) q = 0;
        else if (q > longint'(top)) q = longint'(top);
        return COORD_W'(q);
    endfunction

    always @(posedge aclk) begin
        logic [SAMPLE_BITS-1:0] mx, my, ax, ay;
        logic [TIME_W-1:0]      stamp, since;
        touch_result_t          want, got;
        if (!aresetn) begin
            swap_xy  = 1'b0;
            x_lo     = 16'sd200;
            x_hi     = 16'sd3900;
            y_lo     = 16'sd200;
            y_hi     = 16'sd3900;
            x_top    = 12'd319;
            y_top    = 12'd239;
            hold_ms  = 16'd50;
            pen_held = 1'b0;
            edge_ms  = '0;
            reports_in_flight.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_SWAP_AXES:    swap_xy = cfg_data[0];
                    CFG_RAW_X_LOW:    x_lo    = cfg_data;
                    CFG_RAW_X_HIGH:   x_hi    = cfg_data;
                    CFG_RAW_Y_LOW:    y_lo    = cfg_data;
                    CFG_RAW_Y_HIGH:   y_hi    = cfg_data;
                    CFG_SCREEN_X_MAX: x_top   = cfg_data[COORD_W-1:0];
                    CFG_SCREEN_Y_MAX: y_top   = cfg_data[COORD_W-1:0];
                    CFG_DEBOUNCE_MS:  hold_ms = cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                mx = middle_of(s_tdata[IN_X0_LSB +: SAMPLE_BITS],
                               s_tdata[IN_X1_LSB +: SAMPLE_BITS],
                               s_tdata[IN_X2_LSB +: SAMPLE_BITS]);
                my = middle_of(s_tdata[IN_Y0_LSB +: SAMPLE_BITS],
                               s_tdata[IN_Y1_LSB +: SAMPLE_BITS],
                               s_tdata[IN_Y2_LSB +: SAMPLE_BITS]);
                stamp = s_tdata[IN_NOW_LSB +: TIME_W];
                want  = '0;
                if (s_tdata[IN_PEN_LSB] && mx >= 100 && mx <= 4000
                        && my >= 100 && my <= 4000) begin
                    ax = swap_xy ? my : mx;
                    ay = swap_xy ? mx : my;
                    want.touch = 1'b1;
                    want.col   = scale_axis(ax, x_lo, x_hi, x_top);
                    want.row   = scale_axis(ay, y_lo, y_hi, y_top);
                end
                // wrapping time since the last accepted edge
                since = stamp - edge_ms;
                if (since > TIME_W'(hold_ms) && want.touch != pen_held) begin
                    pen_held = want.touch;
                    edge_ms  = stamp;
                    want.tap = want.touch;
                end
                reports_in_flight.push_back(want);
            end

            if (m_tvalid && m_tready) begin
                got.touch = m_tdata[OUT_VALID_BIT];
                got.col   = m_tdata[OUT_SX_LSB +: COORD_W];
                got.row   = m_tdata[OUT_SY_LSB +: COORD_W];
                got.tap   = m_tdata[OUT_TAP_BIT];
                if (reports_in_flight.size() == 0) begin
                    failures++;
                    $display("%0t: result beat %h with no report pending", $time, m_tdata);
                end else begin
                    want = reports_in_flight.pop_front();
                    if (got !== want) begin
                        failures++;
                        $display("%0t: result mismatch, expected touch=%0b x=%0d y=%0d tap=%0b,",
                                 $time, want.touch, want.col, want.row, want.tap,
                                 " got touch=%0b x=%0d y=%0d tap=%0b",
                                 got.touch, got.col, got.row, got.tap);
                    end
                end
            end
        end
        in_flight = reports_in_flight.size();
    end

endmodule

/* bench/touch_sample_filter_map_tap_test.sv */
// ----------------------------------------------------------------------------
// touch_sample_filter_map_tap_test
// Drives touch reports and register writes into the filter/map/tap block
// with random idle gaps on both sides, runs directed corner reports and then
// random press/release strokes under several calibration settings, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module touch_sample_filter_map_tap_test
    import tsfm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int XS_W        = 3 * SAMPLE_BITS;
    localparam int PHASE_ITEMS = 116;
    localparam int LAST_PHASE  = 8;
    localparam int SAMPLE_TOP  = (1 << SAMPLE_BITS) - 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_PAST_END = 8'd8;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TOP      = 8'hFF;

    typedef struct packed {
        logic [TIME_W-1:0]      now;
        logic [SAMPLE_BITS-1:0] y2, y1, y0, x2, x1, x0;
        logic                   pen;
    } panel_report_t;

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           errors;
    int unsigned           pending;

    int unsigned       items_sent = 0;
    int                cur_debounce = 50;
    bit                tx_gaps = 1'b1;
    logic [TIME_W-1:0] clock_ms;

    touch_sample_filter_map_tap dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    touch_report_checker u_report_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .error_count   (errors),
        .pending_count (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("touch_sample_filter_map_tap_test: errors");
        $finish;
    end

    // mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 19) < 16) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // three conversions around a point, sometimes on the rail limits,
    // sometimes with one wild outlier
    function automatic logic [XS_W-1:0] touch_axis();
        logic [SAMPLE_BITS-1:0] s [3];
        int c, v, spread;
        case ($urandom_range(0, 15))
            0: c = 100;
            1: c = 4000;
            2: c = 99;
            3: c = 4001;
            default: c = $urandom_range(100, 4000);
        endcase
        spread = $urandom_range(0, 1) ? 0 : 8;
        for (int j = 0; j < 3; j++) begin
            v = c + $urandom_range(0, 2 * spread) - spread;
            if (v < 0) v = 0;
            if (v > SAMPLE_TOP) v = SAMPLE_TOP;
            s[j] = SAMPLE_BITS'(v);
        end
        if ($urandom_range(0, 3) == 0) s[$urandom_range(0, 2)] = SAMPLE_BITS'($urandom);
        return {s[2], s[1], s[0]};
    endfunction

    function automatic logic [XS_W-1:0] rail_axis();
        logic [SAMPLE_BITS-1:0] s [3];
        for (int j = 0; j < 3; j++)
            s[j] = $urandom_range(0, 1) ? SAMPLE_BITS'($urandom_range(0, 99))
                                        : SAMPLE_BITS'($urandom_range(4001, SAMPLE_TOP));
        return {s[2], s[1], s[0]};
    endfunction

    // time advance clustered around the debounce window
    function automatic logic [TIME_W-1:0] time_step();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, cur_debounce);
            3:       return cur_debounce;
            4:       return cur_debounce + 1;
            9:       return $urandom;
            default: return cur_debounce + $urandom_range(2, 200);
        endcase
    endfunction

    task automatic send_panel(
        input logic              pen,
        input logic [XS_W-1:0]   xs,
        input logic [XS_W-1:0]   ys,
        input logic [TIME_W-1:0] stamp
    );
        panel_report_t rep;
        int            gap;
        rep.pen = pen;
        {rep.x2, rep.x1, rep.x0} = xs;
        {rep.y2, rep.y1, rep.y0} = ys;
        rep.now = stamp;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata  <= S_TDATA_W'(rep);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(
        input logic [CFG_ADDR_W-1:0] idx,
        input logic [CFG_DATA_W-1:0] val
    );
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        if (idx == CFG_DEBOUNCE_MS) cur_debounce = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_setting(input int ph);
        case (ph)
            1: begin
                // full signed range, reversed y span, both clamp extremes
                write_reg(CFG_SWAP_AXES, 16'hFFFF);
                write_reg(CFG_RAW_X_LOW, 16'h8000);
                write_reg(CFG_RAW_X_HIGH, 16'h7FFF);
                write_reg(CFG_RAW_Y_LOW, 16'h7FFF);
                write_reg(CFG_RAW_Y_HIGH, 16'h8000);
                write_reg(CFG_SCREEN_X_MAX, 16'hFFFF);
                write_reg(CFG_SCREEN_Y_MAX, 16'hF000);
                write_reg(CFG_DEBOUNCE_MS, 16'd0);
                write_reg(CFG_IDX_PAST_END, 16'd0);
                write_reg(CFG_IDX_TOP, 16'd0);
            end
            2: begin
                // zero x span, longest debounce
                write_reg(CFG_SWAP_AXES, 16'hFFFE);
                write_reg(CFG_RAW_X_LOW, 16'd1500);
                write_reg(CFG_RAW_X_HIGH, 16'd1500);
                write_reg(CFG_RAW_Y_LOW, 16'd100);
                write_reg(CFG_RAW_Y_HIGH, 16'd4000);
                write_reg(CFG_SCREEN_X_MAX, 16'd4095);
                write_reg(CFG_SCREEN_Y_MAX, 16'd4095);
                write_reg(CFG_DEBOUNCE_MS, 16'hFFFF);
            end
            3: begin
                write_reg(CFG_SWAP_AXES, 16'd1);
                write_reg(CFG_RAW_X_LOW, 16'd3900);
                write_reg(CFG_RAW_X_HIGH, 16'd200);
                write_reg(CFG_RAW_Y_LOW, 16'hC123);
                write_reg(CFG_RAW_Y_HIGH, 16'hC123);
                write_reg(CFG_SCREEN_X_MAX, CFG_DATA_W'($urandom));
                write_reg(CFG_SCREEN_Y_MAX, CFG_DATA_W'($urandom));
                write_reg(CFG_DEBOUNCE_MS, CFG_DATA_W'($urandom_range(0, 100)));
            end
            LAST_PHASE: begin
                write_reg(CFG_SWAP_AXES, 16'd0);
                write_reg(CFG_RAW_X_LOW, 16'd200);
                write_reg(CFG_RAW_X_HIGH, 16'd3900);
                write_reg(CFG_RAW_Y_LOW, 16'd200);
                write_reg(CFG_RAW_Y_HIGH, 16'd3900);
                write_reg(CFG_SCREEN_X_MAX, 16'd319);
                write_reg(CFG_SCREEN_Y_MAX, 16'd239);
                write_reg(CFG_DEBOUNCE_MS, 16'd50);
            end
            default: begin
                write_reg(CFG_SWAP_AXES, CFG_DATA_W'($urandom));
                write_reg(CFG_RAW_X_LOW, $urandom_range(0, 3) == 0 ?
                          CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 600)));
                write_reg(CFG_RAW_X_HIGH, $urandom_range(0, 3) == 0 ?
                          CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(3300, 4095)));
                write_reg(CFG_RAW_Y_LOW, $urandom_range(0, 3) == 0 ?
                          CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 600)));
                write_reg(CFG_RAW_Y_HIGH, $urandom_range(0, 3) == 0 ?
                          CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(3300, 4095)));
                write_reg(CFG_SCREEN_X_MAX, CFG_DATA_W'($urandom));
                write_reg(CFG_SCREEN_Y_MAX, CFG_DATA_W'($urandom));
                write_reg(CFG_DEBOUNCE_MS, CFG_DATA_W'($urandom_range(0, 300)));
            end
        endcase
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off once the run is underway
    initial begin
        int stall_left;
        bit long_hold_done;
        bit rx_busy;
        stall_left     = 0;
        long_hold_done = 1'b0;
        rx_busy        = 1'b1;
        m_tready       = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 149) == 0) rx_busy = !rx_busy;
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!long_hold_done && items_sent >= 300) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                stall_left = 400;
            end else if (rx_busy && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                stall_left = gap_len() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned start;
        int          n;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // directed reports under reset calibration, debounce 50
        send_panel(1'b0, '0, '0, 32'd0);
        send_panel(1'b1, {3{12'd4095}}, {3{12'd4095}}, 32'd10);
        send_panel(1'b1, {3{12'd99}}, {3{12'd2000}}, 32'd20);
        send_panel(1'b1, {3{12'd2000}}, {3{12'd4001}}, 32'd30);
        send_panel(1'b1, {3{12'd100}}, {3{12'd4000}}, 32'd100);      // tap, both clamps
        send_panel(1'b1, {3{12'hAAA}}, {3{12'h555}}, 32'd110);
        send_panel(1'b1, {3{12'd4001}}, {3{12'd2000}}, 32'd120);    // release too soon
        send_panel(1'b0, {12'h555, 12'hAAA, 12'h555}, {3{12'd2000}}, 32'd151);
        send_panel(1'b1, {3{12'd1000}}, {3{12'd1000}}, 32'd160);
        send_panel(1'b1, {3{12'd1000}}, {3{12'd1000}}, 32'd201);    // exactly the window
        send_panel(1'b1, {3{12'd1000}}, {3{12'd1000}}, 32'd202);
        send_panel(1'b1, {12'd2000, 12'd0, 12'd4095}, {12'd4095, 12'd300, 12'd300}, 32'd210);
        send_panel(1'b1, {12'd4095, 12'd2000, 12'd0}, {12'd300, 12'd4095, 12'd300}, 32'd220);
        send_panel(1'b1, {12'd0, 12'd4095, 12'd2000}, {12'd300, 12'd300, 12'd4095}, 32'd230);
        send_panel(1'b1, {12'd150, 12'd3000, 12'd150}, {12'd0, 12'd150, 12'd3000}, 32'd240);
        send_panel(1'b1, {3{12'd100}}, {3{12'd99}}, 32'd300);
        // time wraps across zero
        send_panel(1'b1, {3{12'd3000}}, {3{12'd500}}, 32'hFFFF_FFF0);
        send_panel(1'b0, {3{12'd3000}}, {3{12'd500}}, 32'h0000_0030);
        send_panel(1'b1, {3{12'd3000}}, {3{12'd500}}, 32'h0000_0050);
        send_panel(1'b1, {3{12'd3000}}, {3{12'd500}}, 32'h0000_0062);
        send_panel(1'b1, {3{12'd3000}}, {3{12'd500}}, 32'h0000_0063);
        clock_ms = 32'h100;

        for (int ph = 1; ph <= LAST_PHASE; ph++) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            wait (pending == 0);
            repeat (3) @(negedge aclk);
            apply_setting(ph);
            tx_gaps = (ph % 3 != 0);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 75) begin
                    // press stroke, then release attempts
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        clock_ms += time_step();
                        send_panel(1'b1, touch_axis(), touch_axis(), clock_ms);
                    end
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        clock_ms += time_step();
                        case ($urandom_range(0, 3))
                            0: send_panel(1'b1, rail_axis(), touch_axis(), clock_ms);
                            1: send_panel(1'b1, touch_axis(), rail_axis(), clock_ms);
                            default: send_panel(1'b0, touch_axis(), touch_axis(), clock_ms);
                        endcase
                    end
                end else begin
                    send_panel(1'($urandom), XS_W'({$urandom, $urandom}),
                               XS_W'({$urandom, $urandom}),
                               $urandom_range(0, 1) ? TIME_W'($urandom) : clock_ms);
                end
            end
        end

        @(negedge aclk) s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("touch_sample_filter_map_tap_test: clean");
        else
            $display("touch_sample_filter_map_tap_test: errors");
        $finish;
    end

endmodule

/* sim.f */
hdl/tsfm_pkg.sv
hdl/tsfm_div.sv
hdl/touch_sample_filter_map_tap.sv
hdl/tsfm_checker.sv
bench/touch_report_checker.sv
bench/touch_sample_filter_map_tap_test.sv
